[design/ctbm_pkg.sv]
package ctbm_pkg;

  // Default number of table entries.
  localparam int CTBM_DEPTH = 16;

  localparam int OP_W     = 3;
  localparam int SLOT_W   = 4;
  localparam int SOCK_W   = 8;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int STATUS_W = 3;
  localparam int SCORE_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE       = 3'd1,
    OP_BIND       = 3'd2,
    OP_CONNECT    = 3'd3,
    OP_DISCONNECT = 3'd4,
    OP_LOOKUP     = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_FAMILY    = 3'd2,
    ST_ZERO_PORT = 3'd3,
    ST_NO_MATCH  = 3'd4,
    ST_UNUSED    = 3'd5
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] laddr;
    logic [PORT_W-1:0] lport;
    logic [ADDR_W-1:0] faddr;
    logic [PORT_W-1:0] fport;
  } query_t;

  typedef struct packed {
    logic [SOCK_W-1:0] socket;
    logic [ADDR_W-1:0] laddr;
    logic [PORT_W-1:0] lport;
    logic [ADDR_W-1:0] faddr;
    logic [PORT_W-1:0] fport;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[design/ctbm_ram.sv]
module ctbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/ctbm_score.sv]
module ctbm_score
  import ctbm_pkg::*;
(
  input  entry_t               entry_i,
  input  query_t               query_i,
  output logic [SCORE_W-1:0]   score_o
);

  logic m_lport;
  logic m_laddr;
  logic m_fport;
  logic m_faddr;

  // A zero query port and a zero entry address both act as wildcards.
  assign m_lport = (query_i.lport == '0) || (entry_i.lport == query_i.lport);
  assign m_laddr = (entry_i.laddr == '0) || (entry_i.laddr == query_i.laddr);
  assign m_fport = (entry_i.fport == query_i.fport);
  assign m_faddr = (entry_i.faddr == query_i.faddr);

  assign score_o = SCORE_W'(m_lport) + SCORE_W'(m_laddr)
                 + SCORE_W'(m_fport) + SCORE_W'(m_faddr);

endmodule

[design/connection_table_best_match_top.sv]
// Lookup: one table entry read per cycle, keeping the best-scoring entry.
// Alloc: walks the valid bits from slot 0 to the first free one.
// Bind, connect, disconnect: read, modify, write of the entry memory; a rejected item skips the write.
// Free and unknown codes: no write to the entry memory.
// One item at a time; the next item is taken once the result is in the output register.
// Reset (rst_ni low, asynchronous) marks every entry free; entry contents are not cleared.
module connection_table_best_match_top
  import ctbm_pkg::*;
#(
  parameter int TableDepth = CTBM_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [SOCK_W-1:0]   socket_id_i,
  input  logic                family_is_inet_i,
  input  logic [ADDR_W-1:0]   local_addr_i,
  input  logic [PORT_W-1:0]   local_port_i,
  input  logic [ADDR_W-1:0]   foreign_addr_i,
  input  logic [PORT_W-1:0]   foreign_port_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   result_slot_o,
  output logic [SOCK_W-1:0]   match_socket_o,
  output logic [ADDR_W-1:0]   match_local_addr_o,
  output logic [PORT_W-1:0]   match_local_port_o,
  output logic [ADDR_W-1:0]   match_foreign_addr_o,
  output logic [PORT_W-1:0]   match_foreign_port_o,
  output logic [SCORE_W-1:0]  match_score_o
);

  localparam int IdxW = $clog2(TableDepth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_MODIFY = 7'b0000100,
    S_ALLOC  = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [TableDepth-1:0] valid_q, valid_d;
  logic                  pv_q, pv_d;
  logic                  out_valid_q, out_valid_d;

  op_e                   op_q, op_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [SOCK_W-1:0]     sock_q, sock_d;
  logic                  inet_q, inet_d;
  query_t                qry_q, qry_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [IdxW-1:0]       pidx_q, pidx_d;
  logic [SCORE_W-1:0]    best_score_q, best_score_d;
  logic [IdxW-1:0]       best_idx_q, best_idx_d;
  entry_t                best_entry_q, best_entry_d;
  status_e               res_status_q, res_status_d;
  logic [SLOT_W-1:0]     res_slot_q, res_slot_d;
  status_e               out_status_q, out_status_d;
  logic [SLOT_W-1:0]     out_slot_q, out_slot_d;
  logic [SCORE_W-1:0]    out_score_q, out_score_d;
  entry_t                out_entry_q, out_entry_d;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  entry_t                ram_wdata;
  logic [IdxW-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                rd_entry;
  logic [SCORE_W-1:0]    score;
  logic [IdxW-1:0]       slot_idx;
  logic                  slot_ok;
  logic                  slot_op;

  ctbm_ram #(
    .Width(ENTRY_W),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  ctbm_score u_score (
    .entry_i(rd_entry),
    .query_i(qry_q),
    .score_o(score)
  );

  assign slot_idx = IdxW'(slot_q);
  assign slot_ok  = (int'(slot_q) < TableDepth) && valid_q[slot_idx];
  assign slot_op  = (op_q == OP_FREE) || (op_q == OP_BIND) ||
                    (op_q == OP_CONNECT) || (op_q == OP_DISCONNECT);

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    pv_d         = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    op_d         = op_q;
    slot_d       = slot_q;
    sock_d       = sock_q;
    inet_d       = inet_q;
    qry_d        = qry_q;
    idx_d        = idx_q;
    pidx_d       = pidx_q;
    best_score_d = best_score_q;
    best_idx_d   = best_idx_q;
    best_entry_d = best_entry_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_score_d  = out_score_q;
    out_entry_d  = out_entry_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = rd_entry;
    ram_raddr    = idx_q;

    // Compare stage of the scan: the entry read last cycle against the best so far.
    if (pv_q && (score > best_score_q)) begin
      best_score_d = score;
      best_idx_d   = pidx_q;
      best_entry_d = rd_entry;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = op_e'(operation_i);
          slot_d       = slot_i;
          sock_d       = socket_id_i;
          inet_d       = family_is_inet_i;
          qry_d.laddr  = local_addr_i;
          qry_d.lport  = local_port_i;
          qry_d.faddr  = foreign_addr_i;
          qry_d.fport  = foreign_port_i;
          idx_d        = '0;
          best_score_d = '0;
          best_idx_d   = '0;
          res_status_d = ST_OK;
          res_slot_d   = slot_i;
          if (operation_i == OP_ALLOC) begin
            state_d = S_ALLOC;
          end else if (operation_i == OP_LOOKUP) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        ram_raddr = slot_idx;
        priority if (!slot_op) begin
          res_slot_d = '0;
          state_d    = S_FIN;
        end else if (!slot_ok) begin
          res_status_d = ST_UNUSED;
          state_d      = S_FIN;
        end else if (op_q == OP_FREE) begin
          valid_d[slot_idx] = 1'b0;
          state_d           = S_FIN;
        end else if (op_q == OP_DISCONNECT) begin
          state_d = S_MODIFY;
        end else if (!inet_q) begin
          res_status_d = ST_FAMILY;
          state_d      = S_FIN;
        end else if (op_q == OP_BIND) begin
          state_d = S_MODIFY;
        end else if (qry_q.fport == '0) begin
          res_status_d = ST_ZERO_PORT;
          state_d      = S_FIN;
        end else begin
          state_d = S_MODIFY;
        end
      end
      S_MODIFY: begin
        // The entry read in the previous cycle is rewritten with the new pair.
        ram_we    = 1'b1;
        ram_waddr = slot_idx;
        if (op_q == OP_BIND) begin
          ram_wdata.laddr = qry_q.laddr;
          ram_wdata.lport = qry_q.lport;
        end else if (op_q == OP_CONNECT) begin
          ram_wdata.faddr = qry_q.faddr;
          ram_wdata.fport = qry_q.fport;
        end else begin
          ram_wdata.faddr = '0;
          ram_wdata.fport = '0;
        end
        state_d = S_FIN;
      end
      S_ALLOC: begin
        if (!valid_q[idx_q]) begin
          valid_d[idx_q]   = 1'b1;
          ram_we           = 1'b1;
          ram_waddr        = idx_q;
          ram_wdata        = '0;
          ram_wdata.socket = sock_q;
          res_slot_d       = SLOT_W'(idx_q);
          state_d          = S_FIN;
        end else if (idx_q == LastIdx) begin
          res_status_d = ST_FULL;
          res_slot_d   = '0;
          state_d      = S_FIN;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_SCAN: begin
        ram_raddr = idx_q;
        pv_d      = valid_q[idx_q];
        pidx_d    = idx_q;
        if (idx_q == LastIdx) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_entry_d = '0;
          out_score_d = '0;
          if (op_q == OP_LOOKUP) begin
            if (best_score_q == '0) begin
              out_status_d = ST_NO_MATCH;
              out_slot_d   = '0;
            end else begin
              out_status_d = ST_OK;
              out_slot_d   = SLOT_W'(best_idx_q);
              out_entry_d  = best_entry_q;
              out_score_d  = best_score_q;
            end
          end else begin
            out_status_d = res_status_q;
            out_slot_d   = res_slot_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    slot_q       <= slot_d;
    sock_q       <= sock_d;
    inet_q       <= inet_d;
    qry_q        <= qry_d;
    idx_q        <= idx_d;
    pidx_q       <= pidx_d;
    best_score_q <= best_score_d;
    best_idx_q   <= best_idx_d;
    best_entry_q <= best_entry_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_score_q  <= out_score_d;
    out_entry_q  <= out_entry_d;
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_status_q;
  assign result_slot_o        = out_slot_q;
  assign match_socket_o       = out_entry_q.socket;
  assign match_local_addr_o   = out_entry_q.laddr;
  assign match_local_port_o   = out_entry_q.lport;
  assign match_foreign_addr_o = out_entry_q.faddr;
  assign match_foreign_port_o = out_entry_q.fport;
  assign match_score_o        = out_score_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a transfer without going busy");

  a_alloc_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) && !valid_q[idx_q] |=> valid_q[$past(idx_q)] && (state_q == S_FIN))
    else $error("alloc did not claim the free slot");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_ALLOC) || (state_q == S_MODIFY))
    else $error("entry memory written outside alloc or modify");

  a_valid_grows_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) <= $countones($past(valid_q)) + 1)
    else $error("more than one entry claimed in a cycle");

  a_no_match_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == ST_NO_MATCH) |-> (out_score_q == '0) && (out_slot_q == '0))
    else $error("no-match result carries a score or slot");

endmodule

[tb/connection_table_best_match_top_tb.sv]
`timescale 1ns / 100ps

module connection_table_best_match_top_tb;
  import ctbm_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 2 * CTBM_DEPTH + 8;
  localparam int RANDOM_ITEMS = 425;

  typedef struct {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [SOCK_W-1:0] sock;
    logic              inet;
    logic [ADDR_W-1:0] laddr;
    logic [PORT_W-1:0] lport;
    logic [ADDR_W-1:0] faddr;
    logic [PORT_W-1:0] fport;
    bit                hold;
  } conn_cmd_t;

  typedef struct {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [SOCK_W-1:0]  sock;
    logic [ADDR_W-1:0]  laddr;
    logic [PORT_W-1:0]  lport;
    logic [ADDR_W-1:0]  faddr;
    logic [PORT_W-1:0]  fport;
    logic [SCORE_W-1:0] score;
  } conn_result_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     operation_i      = '0;
  logic [SLOT_W-1:0]   slot_i           = '0;
  logic [SOCK_W-1:0]   socket_id_i      = '0;
  logic                family_is_inet_i = 1'b0;
  logic [ADDR_W-1:0]   local_addr_i     = '0;
  logic [PORT_W-1:0]   local_port_i     = '0;
  logic [ADDR_W-1:0]   foreign_addr_i   = '0;
  logic [PORT_W-1:0]   foreign_port_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   result_slot_o;
  logic [SOCK_W-1:0]   match_socket_o;
  logic [ADDR_W-1:0]   match_local_addr_o;
  logic [PORT_W-1:0]   match_local_port_o;
  logic [ADDR_W-1:0]   match_foreign_addr_o;
  logic [PORT_W-1:0]   match_foreign_port_o;
  logic [SCORE_W-1:0]  match_score_o;

  connection_table_best_match_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .slot_i              (slot_i),
    .socket_id_i         (socket_id_i),
    .family_is_inet_i    (family_is_inet_i),
    .local_addr_i        (local_addr_i),
    .local_port_i        (local_port_i),
    .foreign_addr_i      (foreign_addr_i),
    .foreign_port_i      (foreign_port_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .result_slot_o       (result_slot_o),
    .match_socket_o      (match_socket_o),
    .match_local_addr_o  (match_local_addr_o),
    .match_local_port_o  (match_local_port_o),
    .match_foreign_addr_o(match_foreign_addr_o),
    .match_foreign_port_o(match_foreign_port_o),
    .match_score_o       (match_score_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Shadow copy of the connection table, updated as each transfer is accepted.
  bit                ent_valid [CTBM_DEPTH] = '{default: 1'b0};
  logic [SOCK_W-1:0] ent_sock  [CTBM_DEPTH] = '{default: '0};
  logic [ADDR_W-1:0] ent_laddr [CTBM_DEPTH] = '{default: '0};
  logic [PORT_W-1:0] ent_lport [CTBM_DEPTH] = '{default: '0};
  logic [ADDR_W-1:0] ent_faddr [CTBM_DEPTH] = '{default: '0};
  logic [PORT_W-1:0] ent_fport [CTBM_DEPTH] = '{default: '0};

  // Occupancy as seen while the stimulus is built, to aim commands at live slots.
  bit gen_used [CTBM_DEPTH] = '{default: 1'b0};

  conn_cmd_t    cmd_queue[$];
  conn_result_t expected_results[$];
  conn_cmd_t    held_cmd;
  int           mismatches  = 0;
  int           cycle_count = 0;
  int           gap_left    = 0;
  int           stall_left  = 0;
  bit           in_calm     = 1'b0;
  bit           out_calm    = 1'b0;

  function automatic conn_result_t apply_conn_op(conn_cmd_t c);
    conn_result_t r;
    int           best_score;
    int           best_idx;
    int           pts;
    bit           found;
    r.status   = ST_OK;
    r.slot     = '0;
    r.sock     = '0;
    r.laddr    = '0;
    r.lport    = '0;
    r.faddr    = '0;
    r.fport    = '0;
    r.score    = '0;
    best_score = 0;
    best_idx   = 0;
    found      = 1'b0;
    case (c.op)
      OP_ALLOC: begin
        for (int i = 0; i < CTBM_DEPTH; i++) begin
          if (!found && !ent_valid[i]) begin
            found    = 1'b1;
            best_idx = i;
          end
        end
        if (!found) begin
          r.status = ST_FULL;
        end else begin
          ent_valid[best_idx] = 1'b1;
          ent_sock[best_idx]  = c.sock;
          ent_laddr[best_idx] = '0;
          ent_lport[best_idx] = '0;
          ent_faddr[best_idx] = '0;
          ent_fport[best_idx] = '0;
          r.slot = best_idx[SLOT_W-1:0];
        end
      end
      OP_FREE, OP_BIND, OP_CONNECT, OP_DISCONNECT: begin
        r.slot = c.slot;
        // A missing entry is reported before any family or port problem.
        if (!ent_valid[c.slot]) begin
          r.status = ST_UNUSED;
        end else if (c.op == OP_FREE) begin
          ent_valid[c.slot] = 1'b0;
        end else if (c.op == OP_DISCONNECT) begin
          ent_faddr[c.slot] = '0;
          ent_fport[c.slot] = '0;
        end else if (!c.inet) begin
          r.status = ST_FAMILY;
        end else if (c.op == OP_BIND) begin
          ent_laddr[c.slot] = c.laddr;
          ent_lport[c.slot] = c.lport;
        end else if (c.fport == '0) begin
          r.status = ST_ZERO_PORT;
        end else begin
          ent_faddr[c.slot] = c.faddr;
          ent_fport[c.slot] = c.fport;
        end
      end
      OP_LOOKUP: begin
        for (int i = 0; i < CTBM_DEPTH; i++) begin
          if (ent_valid[i]) begin
            pts = 0;
            if (c.lport == '0 || ent_lport[i] == c.lport) pts++;
            if (ent_laddr[i] == '0 || ent_laddr[i] == c.laddr) pts++;
            if (ent_fport[i] == c.fport) pts++;
            if (ent_faddr[i] == c.faddr) pts++;
            // Ties keep the lower slot.
            if (pts > best_score) begin
              best_score = pts;
              best_idx   = i;
            end
          end
        end
        if (best_score == 0) begin
          r.status = ST_NO_MATCH;
        end else begin
          r.slot  = best_idx[SLOT_W-1:0];
          r.sock  = ent_sock[best_idx];
          r.laddr = ent_laddr[best_idx];
          r.lport = ent_lport[best_idx];
          r.faddr = ent_faddr[best_idx];
          r.fport = ent_fport[best_idx];
          r.score = best_score[SCORE_W-1:0];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: presents queued commands, with random gaps between transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_conn_op(held_cmd));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].hold && expected_results.size() != 0)) begin
          held_cmd         = cmd_queue.pop_front();
          operation_i      <= held_cmd.op;
          slot_i           <= held_cmd.slot;
          socket_id_i      <= held_cmd.sock;
          family_is_inet_i <= held_cmd.inet;
          local_addr_i     <= held_cmd.laddr;
          local_port_i     <= held_cmd.lport;
          foreign_addr_i   <= held_cmd.faddr;
          foreign_port_i   <= held_cmd.fport;
          in_valid_i       <= 1'b1;
          if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
          gap_left <= in_calm ? 0 : $urandom_range(0, 16);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result transfer and stalls the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    conn_result_t want;
    int           n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      n = stall_left;
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding: status %0h slot %0h",
                 status_o, result_slot_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("result_slot", 32'(want.slot), 32'(result_slot_o));
          check_field("match_socket", 32'(want.sock), 32'(match_socket_o));
          check_field("match_local_addr", want.laddr, match_local_addr_o);
          check_field("match_local_port", 32'(want.lport), 32'(match_local_port_o));
          check_field("match_foreign_addr", want.faddr, match_foreign_addr_o);
          check_field("match_foreign_port", 32'(want.fport), 32'(match_foreign_port_o));
          check_field("match_score", 32'(want.score), 32'(match_score_o));
        end
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        n = out_calm ? 0 : $urandom_range(0, 16);
      end else if (n > 0) begin
        n--;
      end
      stall_left  <= n;
      out_stall_i <= (n > 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("connection_table_best_match_top: mismatch");
      $finish;
    end
  end

  task automatic push_cmd(op_e op, logic [SLOT_W-1:0] slot, logic [SOCK_W-1:0] sock,
                          logic inet, logic [ADDR_W-1:0] laddr, logic [PORT_W-1:0] lport,
                          logic [ADDR_W-1:0] faddr, logic [PORT_W-1:0] fport, bit hold);
    conn_cmd_t c;
    bit        taken;
    c.op    = op;
    c.slot  = slot;
    c.sock  = sock;
    c.inet  = inet;
    c.laddr = laddr;
    c.lport = lport;
    c.faddr = faddr;
    c.fport = fport;
    c.hold  = hold;
    taken   = 1'b0;
    cmd_queue.push_back(c);
    if (op == OP_ALLOC) begin
      for (int i = 0; i < CTBM_DEPTH; i++) begin
        if (!taken && !gen_used[i]) begin
          gen_used[i] = 1'b1;
          taken       = 1'b1;
        end
      end
    end else if (op == OP_FREE) begin
      gen_used[slot] = 1'b0;
    end
  endtask

  // A small pool of addresses and ports makes partial and full matches common.
  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [ADDR_W-1:0] pool [4] = '{32'hC0A8_0001, 32'h0A00_0001, 32'h7F00_0001, 32'hC0A8_0002};
    int                roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 25) return '1;
    if (roll < 70) return pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic logic [PORT_W-1:0] pick_port();
    logic [PORT_W-1:0] pool [4] = '{16'd80, 16'd443, 16'd8080, 16'd1024};
    int                roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 25) return '1;
    if (roll < 70) return pool[$urandom_range(0, 3)];
    return PORT_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    int live[$];
    for (int i = 0; i < CTBM_DEPTH; i++) begin
      if (gen_used[i]) live.push_back(i);
    end
    if (live.size() != 0 && $urandom_range(0, 99) < 85) begin
      return SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
    end
    return SLOT_W'($urandom_range(0, CTBM_DEPTH - 1));
  endfunction

  initial begin
    int  roll;
    int  alloc_w;
    int  free_w;
    int  live_count;
    bit  hold;
    op_e op;

    // Directed: missing entries, both error checks of connect, zero-port bind,
    // wildcards, ties, an empty result, and slot reuse after free.
    push_cmd(OP_LOOKUP, 4'd0, 8'h00, 1'b1, 32'h0A00_0001, 16'd80, 32'h0A00_0002, 16'd81, 1'b0);
    push_cmd(OP_FREE, 4'd0, 8'h00, 1'b1, '0, '0, '0, '0, 1'b0);
    push_cmd(OP_BIND, 4'd15, 8'h00, 1'b1, 32'h0102_0304, 16'd22, '0, '0, 1'b0);
    push_cmd(OP_CONNECT, 4'd3, 8'h00, 1'b0, '0, '0, 32'h0102_0304, 16'd0, 1'b0);
    push_cmd(OP_DISCONNECT, 4'd7, 8'h00, 1'b1, '0, '0, '0, '0, 1'b0);
    push_cmd(OP_ALLOC, 4'd0, 8'h00, 1'b1, '1, '1, '1, '1, 1'b0);
    push_cmd(OP_ALLOC, 4'd9, 8'hFF, 1'b0, '0, '0, '0, '0, 1'b0);
    push_cmd(OP_ALLOC, 4'd0, 8'hA5, 1'b1, '0, '0, '0, '0, 1'b0);
    push_cmd(OP_BIND, 4'd0, 8'h00, 1'b0, '1, '1, '0, '0, 1'b0);
    push_cmd(OP_BIND, 4'd0, 8'h00, 1'b1, '1, '1, '0, '0, 1'b0);
    push_cmd(OP_BIND, 4'd1, 8'h00, 1'b1, '0, '0, '0, '0, 1'b0);
    push_cmd(OP_CONNECT, 4'd0, 8'h00, 1'b1, '0, '0, 32'h0A00_0001, 16'd0, 1'b0);
    push_cmd(OP_CONNECT, 4'd0, 8'h00, 1'b0, '0, '0, 32'h0A00_0001, 16'd0, 1'b0);
    push_cmd(OP_CONNECT, 4'd0, 8'h00, 1'b1, '0, '0, '1, '1, 1'b0);
    push_cmd(OP_CONNECT, 4'd1, 8'h00, 1'b1, '0, '0, 32'h0A00_0001, 16'd1, 1'b0);
    push_cmd(OP_LOOKUP, 4'd0, 8'h00, 1'b1, '1, '1, '1, '1, 1'b0);
    push_cmd(OP_LOOKUP, 4'd0, 8'h00, 1'b1, 32'h1234_5678, 16'd0, 32'h0A00_0001, 16'd1, 1'b1);
    push_cmd(OP_LOOKUP, 4'd0, 8'h00, 1'b1, 32'h1234_5678, 16'h5555, 32'h1, 16'd2, 1'b0);
    push_cmd(OP_DISCONNECT, 4'd0, 8'h00, 1'b1, '0, '0, '0, '0, 1'b0);
    push_cmd(OP_FREE, 4'd1, 8'h00, 1'b1, '0, '0, '0, '0, 1'b0);
    push_cmd(OP_FREE, 4'd2, 8'h00, 1'b1, '0, '0, '0, '0, 1'b0);
    push_cmd(OP_LOOKUP, 4'd0, 8'h00, 1'b1, 32'h1, 16'd7, 32'h5, 16'd9, 1'b0);
    push_cmd(OP_ALLOC, 4'd0, 8'h3C, 1'b1, '0, '0, '0, '0, 1'b0);
    push_cmd(OP_LOOKUP, 4'd0, 8'h00, 1'b1, '0, '0, '0, '0, 1'b0);

    // Random: fill the table past full, then phases that lean toward
    // allocation, toward release, or neither.
    alloc_w = 30;
    free_w  = 8;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      live_count = 0;
      for (int i = 0; i < CTBM_DEPTH; i++) live_count += gen_used[i];
      if (n % 60 == 0 && n != 0) begin
        case ($urandom_range(0, 2))
          0: begin alloc_w = 30; free_w = 8; end
          1: begin alloc_w = 8; free_w = 30; end
          default: begin alloc_w = 17; free_w = 15; end
        endcase
      end
      hold = (n % 100 == 50);
      roll = $urandom_range(0, 99);
      if (n < 20 && (live_count < CTBM_DEPTH || n < 18)) roll = 0;
      if (roll < alloc_w) op = OP_ALLOC;
      else if (roll < alloc_w + free_w) op = OP_FREE;
      else if (roll < alloc_w + free_w + 15) op = OP_BIND;
      else if (roll < alloc_w + free_w + 30) op = OP_CONNECT;
      else if (roll < alloc_w + free_w + 36) op = OP_DISCONNECT;
      else op = OP_LOOKUP;
      push_cmd(op, pick_slot(), SOCK_W'($urandom_range(0, 255)), $urandom_range(0, 9) != 0,
               pick_addr(), pick_port(), pick_addr(), pick_port(), hold);
    end

    do @(posedge clk_i);
    while (cmd_queue.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("connection_table_best_match_top: match");
    end else begin
      $display("connection_table_best_match_top: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
design/ctbm_pkg.sv
design/ctbm_ram.sv
design/ctbm_score.sv
design/connection_table_best_match_top.sv
tb/connection_table_best_match_top_tb.sv
